### design/xtea_pkg.sv
// Shared types, constants and round-key helpers for the XTEA block cipher.
package xtea_pkg;

  localparam int unsigned HalfRounds = 64;
  localparam logic [31:0] Delta      = 32'h9E37_79B9;
  localparam int unsigned WordW      = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned ShiftL     = 4;
  localparam int unsigned ShiftR     = 5;
  localparam int unsigned SelShift   = 11;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_e;

  typedef logic [WordW-1:0] word_t;

  // One slot of the round pipeline.
  typedef struct packed {
    logic  valid;
    cmd_e  cmd;
    word_t a;
    word_t b;
    logic  last;
  } stage_t;

  // Output skid status seen by the top level.
  typedef struct packed {
    logic en;
    logic full;
  } skid_stat_t;

  // Sum constant of half-round h.
  function automatic word_t round_sum(int unsigned h);
    logic [63:0] p;
    p = 64'(Delta) * 64'((h + 1) >> 1);
    return p[WordW-1:0];
  endfunction

  // Key word picked by half-round h.
  function automatic logic [1:0] round_sel(int unsigned h);
    word_t s;
    s = round_sum(h);
    return h[0] ? s[SelShift+1:SelShift] : s[1:0];
  endfunction

  // Set when stage j updates word b while encrypting.
  function automatic logic enc_upd_b(int unsigned j);
    return j[0];
  endfunction

  // Set when stage j updates word b while decrypting.
  function automatic logic dec_upd_b(int unsigned j);
    int unsigned h;
    h = HalfRounds - 1 - j;
    return h[0];
  endfunction

endpackage

### design/xtea_if.sv
// Valid/ready channel interfaces for blocks in and results out.
interface xtea_in_if;
  logic                valid;
  logic                ready;
  logic                command;
  xtea_pkg::word_t     block_word_a;
  xtea_pkg::word_t     block_word_b;
  logic                last_block;

  modport source (output valid, command, block_word_a, block_word_b, last_block,
                  input ready);
  modport sink   (input valid, command, block_word_a, block_word_b, last_block,
                  output ready);
endinterface

interface xtea_out_if;
  logic                valid;
  logic                ready;
  xtea_pkg::word_t     result_word_a;
  xtea_pkg::word_t     result_word_b;
  logic                last_block_out;

  modport source (output valid, result_word_a, result_word_b, last_block_out,
                  input ready);
  modport sink   (input valid, result_word_a, result_word_b, last_block_out,
                  output ready);
endinterface

### design/xtea_key_sched.sv
// Key registers and the registered round-key table for every half-round.
module xtea_key_sched (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [xtea_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  xtea_pkg::word_t                     cfg_data_i,
  output xtea_pkg::word_t                     rk_o [xtea_pkg::HalfRounds]
);

  xtea_pkg::word_t key_q [4];
  xtea_pkg::word_t rk_q  [xtea_pkg::HalfRounds];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) key_q[k] <= '0;
    end else if (cfg_we_i) begin
      case (xtea_pkg::cfg_reg_e'(cfg_idx_i))
        xtea_pkg::REG_KEY0: key_q[0] <= cfg_data_i;
        xtea_pkg::REG_KEY1: key_q[1] <= cfg_data_i;
        xtea_pkg::REG_KEY2: key_q[2] <= cfg_data_i;
        xtea_pkg::REG_KEY3: key_q[3] <= cfg_data_i;
        default: ;  // drop writes beyond the key words
      endcase
    end
  end

  // Round key = constant sum + selected key word; the user must change keys only while idle, not enforced here.
  for (genvar h = 0; h < xtea_pkg::HalfRounds; h++) begin : g_rk
    localparam xtea_pkg::word_t SumC = xtea_pkg::round_sum(h);
    localparam logic [1:0]      SelC = xtea_pkg::round_sel(h);
    always_ff @(posedge clk_i) begin
      rk_q[h] <= SumC + key_q[SelC];
    end
  end

  assign rk_o = rk_q;

endmodule

### design/xtea_stage.sv
// One half-round of the cipher pipeline with its stage register.
module xtea_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  xtea_pkg::stage_t       stage_i,
  input  xtea_pkg::word_t        rk_enc_i,
  input  xtea_pkg::word_t        rk_dec_i,
  input  logic                   upd_b_enc_i,
  input  logic                   upd_b_dec_i,
  output xtea_pkg::stage_t       stage_o
);

  logic             dec;
  logic             upd_b;
  xtea_pkg::word_t  rk;
  xtea_pkg::word_t  x;
  xtea_pkg::word_t  f;
  xtea_pkg::word_t  tgt;
  xtea_pkg::word_t  nxt;
  logic             valid_q;
  xtea_pkg::stage_t data_q;
  xtea_pkg::stage_t data_d;

  always_comb begin
    dec   = (stage_i.cmd == xtea_pkg::CMD_DECRYPT);
    upd_b = dec ? upd_b_dec_i : upd_b_enc_i;
    rk    = dec ? rk_dec_i : rk_enc_i;
    x     = upd_b ? stage_i.a : stage_i.b;
    f     = (((x << xtea_pkg::ShiftL) ^ (x >> xtea_pkg::ShiftR)) + x) ^ rk;
    tgt   = upd_b ? stage_i.b : stage_i.a;
    nxt   = dec ? (tgt - f) : (tgt + f);
    data_d       = stage_i;
    data_d.valid = 1'b0;
    if (upd_b) begin
      data_d.b = nxt;
    end else begin
      data_d.a = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    stage_o       = data_q;
    stage_o.valid = valid_q;
  end

endmodule

### design/xtea_out_skid.sv
// Output skid register that parts the pipeline from the result channel.
module xtea_out_skid (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  xtea_pkg::stage_t      pipe_i,
  xtea_out_if.source            out,
  output xtea_pkg::skid_stat_t  stat_o
);

  logic             full_q;
  logic             full_d;
  xtea_pkg::stage_t skid_q;

  always_comb begin
    full_d = full_q;
    if (full_q && out.ready) begin
      full_d = 1'b0;
    end else if (!full_q && pipe_i.valid && !out.ready) begin
      full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  // Catch the beat leaving the pipeline when the sink stalls.
  always_ff @(posedge clk_i) begin
    if (!full_q) begin
      skid_q <= pipe_i;
    end
  end

  assign out.valid          = full_q | pipe_i.valid;
  assign out.result_word_a  = full_q ? skid_q.a : pipe_i.a;
  assign out.result_word_b  = full_q ? skid_q.b : pipe_i.b;
  assign out.last_block_out = full_q ? skid_q.last : pipe_i.last;

  assign stat_o.en   = !full_q;
  assign stat_o.full = full_q;

endmodule

### design/xtea_block_cipher.sv
// Top level of the pipelined XTEA block cipher.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------------------
//  in_i     | in  | valid / ready  | command, block_word_a, block_word_b, last
//  out_o    | out | valid / ready  | result_word_a, result_word_b, last_out
//  cfg      | in  | cfg_we_i       | cfg_idx_i, cfg_data_i (key words 0..3)
//
// One block enters every cycle while the output skid is empty; each of the
// HALF_ROUNDS (64) pipeline stages runs one half-round. The round keys come
// from a registered table, loaded from the key registers after a key write.
// Reset clears the key words, the stage valid bits and the skid full flag.
// A stalled sink fills the output skid first; only then does the pipeline
// hold, and in_i.ready follows the skid, not out_o.ready.
module xtea_block_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  xtea_in_if.sink                       in_i,
  xtea_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [xtea_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  xtea_pkg::word_t               cfg_data_i
);

  xtea_pkg::word_t      rk [xtea_pkg::HalfRounds];
  xtea_pkg::stage_t     stage_in  [xtea_pkg::HalfRounds];
  xtea_pkg::stage_t     stage_out [xtea_pkg::HalfRounds];
  xtea_pkg::skid_stat_t skid_stat;
  logic                 en;

  xtea_key_sched u_key_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rk_o       (rk)
  );

  // Advance the whole pipeline while the skid is empty.
  assign en         = skid_stat.en;
  assign in_i.ready = en;

  assign stage_in[0] = '{
    valid: in_i.valid,
    cmd:   xtea_pkg::cmd_e'(in_i.command),
    a:     in_i.block_word_a,
    b:     in_i.block_word_b,
    last:  in_i.last_block
  };

  for (genvar j = 0; j < xtea_pkg::HalfRounds; j++) begin : g_stage
    // Decryption walks the half-rounds backward.
    localparam int unsigned DecIdx = xtea_pkg::HalfRounds - 1 - j;
    localparam logic        UpdEnc = xtea_pkg::enc_upd_b(j);
    localparam logic        UpdDec = xtea_pkg::dec_upd_b(j);

    if (j > 0) begin : g_link
      assign stage_in[j] = stage_out[j-1];
    end

    xtea_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .stage_i     (stage_in[j]),
      .rk_enc_i    (rk[j]),
      .rk_dec_i    (rk[DecIdx]),
      .upd_b_enc_i (UpdEnc),
      .upd_b_dec_i (UpdDec),
      .stage_o     (stage_out[j])
    );
  end

  xtea_out_skid u_out_skid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pipe_i (stage_out[xtea_pkg::HalfRounds-1]),
    .out    (out_o),
    .stat_o (skid_stat)
  );

`ifndef SYNTHESIS
  // A held pipeline keeps its final stage unchanged.
  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(stage_out[xtea_pkg::HalfRounds-1]))
    else $error("final stage changed during hold");

  // A beat leaving the pipeline into a stalled sink lands in the skid.
  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && stage_out[xtea_pkg::HalfRounds-1].valid && !out_o.ready) |=> skid_stat.full)
    else $error("stalled result not caught by skid");

  // Input backpressure only occurs while a result is on offer.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled without pending result");
`endif

endmodule
